// ===== design/mdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// mdpt_pkg: shared definitions for the masked depth-to-point transform
// Holds the register index codes, register reset values and the fixed
// field widths of the stream words.
// ---------------------------------------------------------------------------
package mdpt_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	// Register index codes; the unused index is ignored on write.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_SCALE = 3'd0,
		REG_INV_FOCAL   = 3'd1,
		REG_PRINCIPAL   = 3'd2,
		REG_ROT_ROW0    = 3'd3,
		REG_ROT_ROW1    = 3'd4,
		REG_ROT_ROW2    = 3'd5,
		REG_TRANSLATION = 3'd6
	} cfg_reg_t;

	// Register widths.
	localparam int SCALE_W = 16;
	localparam int FOCAL_W = 24;
	localparam int PP_W    = 24;
	localparam int ROW_W   = 48;
	localparam int TRANS_W = 60;

	// Register reset values.
	localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 16'd3355;
	localparam logic [FOCAL_W-1:0] RST_INV_FOCAL   = 24'd31957;
	localparam logic [PP_W-1:0]    RST_PRINCIPAL   = 24'd1962623;
	localparam logic [ROW_W-1:0]   RST_ROT_ROW0    = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0]   RST_ROT_ROW1    = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0]   RST_ROT_ROW2    = 48'h4000_0000_0000;
	localparam logic [TRANS_W-1:0] RST_TRANSLATION = 60'd0;

	// Field widths of the stream words.
	localparam int DEPTH_W  = 16;
	localparam int MASK_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int COORD_W  = 32;
	localparam int ENTRY_W  = 16;
	localparam int TCOMP_W  = 20;
	localparam int CP_W     = 12;
	localparam int OUT_W    = 3 * COORD_W + 3 * COLOR_W;

	// Depth in Q16.16 meters is at most 25 bits; focal times depth is 49 bits.
	localparam int D_W      = 25;
	localparam int FD_W     = FOCAL_W + D_W;
	localparam int FD_LO_W  = 25;
	localparam int FD_HI_W  = FD_W - FD_LO_W;

endpackage

// ===== design/masked_depth_to_point_transform.sv =====
// ---------------------------------------------------------------------------
// masked_depth_to_point_transform: depth pixel to world point
// Back-projects masked depth pixels through a pinhole camera and applies a
// rigid transform, passing the color bytes along with each point.
// ---------------------------------------------------------------------------
// The block takes one pixel word per clock while it is not stalled and, unless
// its mask byte is zero, returns one point word for it; a masked pixel is
// consumed and produces no word. Throughput is one pixel per cycle while the
// output is not stalled, set by a seven-stage pipeline with a register after
// every multiplier: depth scaling, focal times depth, the split
// camera-coordinate products, their recombination, the nine rotation products,
// the rounded row sums and the translation with saturation. Each stage holds
// its word independently, so input words are still taken while a finished
// point waits at the output, as long as some stage ahead of it is empty.
// Configuration is written through a plain write port and must only change while the pipeline is empty.
module masked_depth_to_point_transform #(
	parameter int ROW_BITS = 11,
	parameter int COL_BITS = 11
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration write port.
	input  logic                           cfg_wen,
	input  logic [mdpt_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mdpt_pkg::CFG_DATA_W-1:0] cfg_wdata,

	// Pixel stream.
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0 up: pixel_row, pixel_col, depth_raw, mask_value,
	// chan0, chan1, chan2, zero padding to whole bytes.
	input  logic [((ROW_BITS + COL_BITS + 48 + 7) / 8) * 8 - 1:0] s_axis_tdata,

	// Point stream.
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0 up: world_x, world_y, world_z, color_r, color_g,
	// color_b.
	output logic [mdpt_pkg::OUT_W-1:0] m_axis_tdata
);
	import mdpt_pkg::*;

	// Field offsets in the input word.
	localparam int COL_LSB   = ROW_BITS;
	localparam int DEPTH_LSB = COL_LSB + COL_BITS;
	localparam int MASK_LSB  = DEPTH_LSB + DEPTH_W;
	localparam int CHAN_LSB  = MASK_LSB + MASK_W;

	// Pixel offsets from the principal point, in half pixels.
	localparam int AXB = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
	localparam int UVW = ((AXB + 1 > CP_W) ? AXB + 1 : CP_W) + 1;
	// Split products of an offset with focal times depth.
	localparam int PLW = UVW + FD_LO_W + 1;
	localparam int PHW = UVW + FD_HI_W + 1;
	// Camera coordinate, rotation product, row sum and world widths.
	localparam int CW  = UVW + 24;
	localparam int PW  = ENTRY_W + CW;
	localparam int SW  = PW + 2;
	localparam int AW  = CW + 4;
	localparam int WW  = AW + 1;

	localparam logic signed [PLW-1:0] PL_HALF  = PLW'(1) << (FD_LO_W - 1);
	localparam logic signed [SW-1:0]  SUM_HALF = SW'(1) << 13;
	localparam logic signed [WW-1:0]  SAT_MAX  = WW'(32'h7FFF_FFFF);
	localparam logic signed [WW-1:0]  SAT_MIN  = -(WW'(33'h0_8000_0000));

	// -----------------------------------------------------------------------
	// Configuration registers
	// -----------------------------------------------------------------------
	logic [SCALE_W-1:0] depth_scale_q;
	logic [FOCAL_W-1:0] inv_focal_q;
	logic [PP_W-1:0]    principal_q;
	logic [ROW_W-1:0]   rot_q [3];
	logic [TRANS_W-1:0] translation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= RST_DEPTH_SCALE;
			inv_focal_q   <= RST_INV_FOCAL;
			principal_q   <= RST_PRINCIPAL;
			rot_q[0]      <= RST_ROT_ROW0;
			rot_q[1]      <= RST_ROT_ROW1;
			rot_q[2]      <= RST_ROT_ROW2;
			translation_q <= RST_TRANSLATION;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_addr))
				REG_DEPTH_SCALE: depth_scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_INV_FOCAL:   inv_focal_q   <= cfg_wdata[FOCAL_W-1:0];
				REG_PRINCIPAL:   principal_q   <= cfg_wdata[PP_W-1:0];
				REG_ROT_ROW0:    rot_q[0]      <= cfg_wdata[ROW_W-1:0];
				REG_ROT_ROW1:    rot_q[1]      <= cfg_wdata[ROW_W-1:0];
				REG_ROT_ROW2:    rot_q[2]      <= cfg_wdata[ROW_W-1:0];
				REG_TRANSLATION: translation_q <= cfg_wdata[TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Stage valid bits and load enables
	// -----------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	// A stage loads when it is empty or its word moves on in the same cycle.
	always_comb begin
		ld7 = !vld_s7 || m_axis_tready;
		ld6 = !vld_s6 || ld7;
		ld5 = !vld_s5 || ld6;
		ld4 = !vld_s4 || ld5;
		ld3 = !vld_s3 || ld4;
		ld2 = !vld_s2 || ld3;
		ld1 = !vld_s1 || ld2;
	end

	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			// A masked pixel is accepted but enters as a bubble.
			if (ld1) vld_s1 <= s_axis_tvalid && (s_axis_tdata[MASK_LSB +: MASK_W] != '0);
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: depth to meters and offsets from the principal point
	// -----------------------------------------------------------------------
	logic [ROW_BITS-1:0] in_row;
	logic [COL_BITS-1:0] in_col;
	logic [DEPTH_W-1:0]  in_depth;
	logic [2*DEPTH_W:0]  dsum;
	logic [UVW-1:0]      uoff, voff;

	always_comb begin
		in_row   = s_axis_tdata[ROW_BITS-1:0];
		in_col   = s_axis_tdata[COL_LSB +: COL_BITS];
		in_depth = s_axis_tdata[DEPTH_LSB +: DEPTH_W];
		dsum     = (2*DEPTH_W+1)'(in_depth) * (2*DEPTH_W+1)'(depth_scale_q)
		           + (2*DEPTH_W+1)'(128);
		uoff     = UVW'({in_col, 1'b0}) - UVW'(principal_q[CP_W-1:0]);
		voff     = UVW'({in_row, 1'b0}) - UVW'(principal_q[2*CP_W-1:CP_W]);
	end

	logic [D_W-1:0]         d_s1;
	logic signed [UVW-1:0]  uoff_s1, voff_s1;
	logic [3*COLOR_W-1:0]   color_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			d_s1     <= dsum[2*DEPTH_W:8];
			uoff_s1  <= $signed(uoff);
			voff_s1  <= $signed(voff);
			color_s1 <= s_axis_tdata[CHAN_LSB +: 3*COLOR_W];
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2: reciprocal focal length times depth
	// -----------------------------------------------------------------------
	logic [FD_W-1:0]        fd_s2;
	logic [D_W-1:0]         d_s2;
	logic signed [UVW-1:0]  uoff_s2, voff_s2;
	logic [3*COLOR_W-1:0]   color_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			fd_s2    <= FD_W'(inv_focal_q) * FD_W'(d_s1);
			d_s2     <= d_s1;
			uoff_s2  <= uoff_s1;
			voff_s2  <= voff_s1;
			color_s2 <= color_s1;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 3: offsets times the low and high halves of focal times depth
	// -----------------------------------------------------------------------
	logic signed [PLW-1:0]  pxl_s3, pyl_s3;
	logic signed [PHW-1:0]  pxh_s3, pyh_s3;
	logic [D_W-1:0]         d_s3;
	logic [3*COLOR_W-1:0]   color_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			pxl_s3   <= PLW'(uoff_s2) * PLW'($signed({1'b0, fd_s2[FD_LO_W-1:0]}));
			pyl_s3   <= PLW'(voff_s2) * PLW'($signed({1'b0, fd_s2[FD_LO_W-1:0]}));
			pxh_s3   <= PHW'(uoff_s2) * PHW'($signed({1'b0, fd_s2[FD_W-1:FD_LO_W]}));
			pyh_s3   <= PHW'(voff_s2) * PHW'($signed({1'b0, fd_s2[FD_W-1:FD_LO_W]}));
			d_s3     <= d_s2;
			color_s3 <= color_s2;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 4: camera point, the low half rounded to nearest
	// -----------------------------------------------------------------------
	logic signed [PLW-1:0] xl_rnd, yl_rnd, xl_sh, yl_sh;

	always_comb begin
		xl_rnd = pxl_s3 + PL_HALF;
		yl_rnd = pyl_s3 + PL_HALF;
		xl_sh  = xl_rnd >>> FD_LO_W;
		yl_sh  = yl_rnd >>> FD_LO_W;
	end

	logic signed [CW-1:0]  cam_s4 [3];
	logic [3*COLOR_W-1:0]  color_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			cam_s4[0] <= $signed(pxh_s3[CW-1:0]) + $signed(xl_sh[CW-1:0]);
			cam_s4[1] <= $signed(pyh_s3[CW-1:0]) + $signed(yl_sh[CW-1:0]);
			cam_s4[2] <= $signed(CW'(d_s3));
			color_s4  <= color_s3;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 5: the nine rotation products
	// -----------------------------------------------------------------------
	logic signed [PW-1:0]  prod_s5 [3][3];
	logic [3*COLOR_W-1:0]  color_s5;

	always_ff @(posedge clk) begin
		if (ld5) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s5[i][k] <= PW'($signed(rot_q[i][ENTRY_W*k +: ENTRY_W]))
					                 * PW'(cam_s4[k]);
				end
			end
			color_s5 <= color_s4;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 6: row sums rounded back to Q16.16
	// -----------------------------------------------------------------------
	logic signed [SW-1:0] rsum [3];
	logic signed [SW-1:0] rsh  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = SW'(prod_s5[i][0]) + SW'(prod_s5[i][1]) + SW'(prod_s5[i][2])
			          + SUM_HALF;
			rsh[i]  = rsum[i] >>> 14;
		end
	end

	logic signed [AW-1:0]  acc_s6 [3];
	logic [3*COLOR_W-1:0]  color_s6;

	always_ff @(posedge clk) begin
		if (ld6) begin
			for (int i = 0; i < 3; i++) begin
				acc_s6[i] <= $signed(rsh[i][AW-1:0]);
			end
			color_s6 <= color_s5;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 7: translation and saturation into the output word
	// -----------------------------------------------------------------------
	logic signed [WW-1:0]      wsum [3];
	logic signed [WW-1:0]      tsh  [3];
	logic [COORD_W-1:0]        wsat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tsh[i]  = WW'($signed({translation_q[TCOMP_W*i +: TCOMP_W], 6'b0}));
			wsum[i] = WW'(acc_s6[i]) + tsh[i];
			if (wsum[i] > SAT_MAX) begin
				wsat[i] = SAT_MAX[COORD_W-1:0];
			end else if (wsum[i] < SAT_MIN) begin
				wsat[i] = SAT_MIN[COORD_W-1:0];
			end else begin
				wsat[i] = wsum[i][COORD_W-1:0];
			end
		end
	end

	logic [COORD_W-1:0]    world_s7 [3];
	logic [3*COLOR_W-1:0]  color_s7;

	always_ff @(posedge clk) begin
		if (ld7) begin
			for (int i = 0; i < 3; i++) begin
				world_s7[i] <= wsat[i];
			end
			color_s7 <= color_s6;
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {color_s7, world_s7[2], world_s7[1], world_s7[0]};

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: stream test of the masked depth-to-point transform
// Drives pixel words and configuration writes into the block, predicts the
// point word of every unmasked pixel with a bit-accurate fixed-point model of
// the back-projection and rigid transform, and checks each point word field
// by field in arrival order. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
	import mdpt_pkg::*;

	localparam int ROW_BITS = 11;
	localparam int COL_BITS = 11;
	localparam int IN_W     = ((ROW_BITS + COL_BITS + 48 + 7) / 8) * 8;
	localparam int PHASES   = 9;
	localparam int PHASE_LEN = 250;
	localparam int SETTLE   = 16;
	localparam int LIMIT    = 300000;

	// Write to this index must leave every register untouched.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// One pixel word, first field in the lowest bits.
	typedef struct packed {
		logic [COLOR_W-1:0]  chan2;
		logic [COLOR_W-1:0]  chan1;
		logic [COLOR_W-1:0]  chan0;
		logic [MASK_W-1:0]   mask;
		logic [DEPTH_W-1:0]  depth;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} pixel_t;

	// One point word, world_x in the lowest bits.
	typedef struct packed {
		logic [COLOR_W-1:0] color_b;
		logic [COLOR_W-1:0] color_g;
		logic [COLOR_W-1:0] color_r;
		logic [COORD_W-1:0] world_z;
		logic [COORD_W-1:0] world_y;
		logic [COORD_W-1:0] world_x;
	} point_t;

	localparam int PIX_W = $bits(pixel_t);

	// Point predictor and in-order store of the points still to arrive.
	class point_scoreboard;
		logic [SCALE_W-1:0] scale;
		logic [FOCAL_W-1:0] focal;
		logic [PP_W-1:0]    center;
		logic [ROW_W-1:0]   rot [3];
		logic [TRANS_W-1:0] shift;
		point_t             points_due [$];
		int                 errors;
		int                 seen;

		function new();
			scale  = RST_DEPTH_SCALE;
			focal  = RST_INV_FOCAL;
			center = RST_PRINCIPAL;
			rot[0] = RST_ROT_ROW0;
			rot[1] = RST_ROT_ROW1;
			rot[2] = RST_ROT_ROW2;
			shift  = RST_TRANSLATION;
			errors = 0;
			seen   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEPTH_SCALE: scale  = data[SCALE_W-1:0];
				REG_INV_FOCAL:   focal  = data[FOCAL_W-1:0];
				REG_PRINCIPAL:   center = data[PP_W-1:0];
				REG_ROT_ROW0:    rot[0] = data[ROW_W-1:0];
				REG_ROT_ROW1:    rot[1] = data[ROW_W-1:0];
				REG_ROT_ROW2:    rot[2] = data[ROW_W-1:0];
				REG_TRANSLATION: shift  = data[TRANS_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return points_due.size();
		endfunction

		// Signed Q2.14 rotation entry k of a row.
		function longint rot_entry(logic [ROW_W-1:0] r, int k);
			logic signed [ENTRY_W-1:0] e;
			e = r[ENTRY_W*k +: ENTRY_W];
			return longint'(e);
		endfunction

		// One world axis: rounded row sum, plus the offset, saturated.
		function logic [COORD_W-1:0] world_axis(int axis, longint c0, longint c1, longint c2);
			logic signed [TCOMP_W-1:0] t;
			longint acc;
			t = shift[TCOMP_W*axis +: TCOMP_W];
			acc = rot_entry(rot[axis], 0) * c0 + rot_entry(rot[axis], 1) * c1
				+ rot_entry(rot[axis], 2) * c2;
			acc = ((acc + 64'sd8192) >>> 14) + longint'(t) * 64;
			if (acc > SAT_HI)
				acc = SAT_HI;
			if (acc < SAT_LO)
				acc = SAT_LO;
			return acc[COORD_W-1:0];
		endfunction

		// Work out the point of an accepted pixel; masked pixels give none.
		function void note_pixel(pixel_t p);
			longint dep, scl, inv, cx2, cy2, d, u, v, xc, yc;
			point_t pt;
			if (p.mask == '0)
				return;
			dep = longint'(p.depth);
			scl = longint'(scale);
			inv = longint'(focal);
			cx2 = longint'(center[CP_W-1:0]);
			cy2 = longint'(center[2*CP_W-1:CP_W]);
			d   = (dep * scl + 64'sd128) >>> 8;
			u   = 2 * longint'(p.col) - cx2;
			v   = 2 * longint'(p.row) - cy2;
			xc  = (u * inv * d + 64'sd16777216) >>> 25;
			yc  = (v * inv * d + 64'sd16777216) >>> 25;
			pt.world_x = world_axis(0, xc, yc, d);
			pt.world_y = world_axis(1, xc, yc, d);
			pt.world_z = world_axis(2, xc, yc, d);
			pt.color_r = p.chan0;
			pt.color_g = p.chan1;
			pt.color_b = p.chan2;
			points_due = {points_due, pt};
		endfunction

		task report(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
			errors++;
			if (errors <= 50)
				$display("mismatch on %s of point %0d: got %h, want %h", what, seen, got, want);
		endtask

		// Compare an arrived point with the oldest prediction.
		task check_point(point_t got);
			point_t want;
			if (points_due.size() == 0) begin
				report("unpredicted word", got.world_x, '0);
				seen++;
				return;
			end
			want = points_due.pop_front();
			if (got.world_x !== want.world_x)
				report("world_x", got.world_x, want.world_x);
			if (got.world_y !== want.world_y)
				report("world_y", got.world_y, want.world_y);
			if (got.world_z !== want.world_z)
				report("world_z", got.world_z, want.world_z);
			if (got.color_r !== want.color_r)
				report("color_r", COORD_W'(got.color_r), COORD_W'(want.color_r));
			if (got.color_g !== want.color_g)
				report("color_g", COORD_W'(got.color_g), COORD_W'(want.color_g));
			if (got.color_b !== want.color_b)
				report("color_b", COORD_W'(got.color_b), COORD_W'(want.color_b));
			seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// Fields from bit 0 up: pixel_row, pixel_col, depth_raw, mask_value,
	// chan0, chan1, chan2, zero padding.
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// Fields from bit 0 up: world_x, world_y, world_z, color_r, color_g,
	// color_b.
	logic [OUT_W-1:0] m_axis_tdata;

	// While set, neither side idles.
	logic calm = 1'b0;
	int cycles = 0;
	point_scoreboard sb;

	masked_depth_to_point_transform #(
		.ROW_BITS(ROW_BITS),
		.COL_BITS(COL_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Random stalls on the point side.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 8);
	end

	// Watch both handshakes: note accepted pixels, check arriving points.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_pixel(s_axis_tdata[PIX_W-1:0]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_point(m_axis_tdata);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAIL masked_depth_to_point_transform");
			$finish;
		end
	end

	function automatic logic [59:0] rand60();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[59:0];
	endfunction

	// Rotation row; a plausible row keeps every entry within plus or minus one.
	function automatic logic [ROW_W-1:0] rand_row(bit plausible);
		logic [ROW_W-1:0] r;
		int e;
		r = ROW_W'(rand60());
		if (plausible) begin
			for (int k = 0; k < 3; k++) begin
				e = $urandom_range(32768);
				e -= 16384;
				r[ENTRY_W*k +: ENTRY_W] = e[ENTRY_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.row = ROW_BITS'($urandom_range(2047));
		p.col = COL_BITS'($urandom_range(2047));
		if ($urandom_range(7) == 0)
			p.depth = $urandom_range(1) ? '1 : '0;
		else
			p.depth = DEPTH_W'($urandom_range(65535));
		p.mask = ($urandom_range(7) == 0) ? '0 : MASK_W'($urandom_range(255));
		p.chan0 = COLOR_W'($urandom_range(255));
		p.chan1 = COLOR_W'($urandom_range(255));
		p.chan2 = COLOR_W'($urandom_range(255));
		return p;
	endfunction

	function automatic pixel_t make_pixel(int row, int col, int depth, int mask, int c0, int c1,
		int c2);
		pixel_t p;
		p.row = ROW_BITS'(row);
		p.col = COL_BITS'(col);
		p.depth = DEPTH_W'(depth);
		p.mask = MASK_W'(mask);
		p.chan0 = COLOR_W'(c0);
		p.chan1 = COLOR_W'(c1);
		p.chan2 = COLOR_W'(c2);
		return p;
	endfunction

	// Offer one pixel word, with random idle cycles ahead of it.
	task automatic send_pixel(pixel_t p);
		if (!calm) begin
			while ($urandom_range(99) < 8) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - PIX_W){1'b0}}, p};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic stop_pixels();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every predicted point, then let the pipeline run empty.
	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Load one register setting; the first ones are the extremes.
	task automatic apply_setting(int kind);
		logic [CFG_DATA_W-1:0] v [7];
		bit plausible;
		plausible = kind[0];
		v[REG_DEPTH_SCALE] = rand60();
		v[REG_INV_FOCAL]   = plausible ? 60'($urandom_range(1 << 17, 1)) : rand60();
		v[REG_PRINCIPAL]   = rand60();
		v[REG_ROT_ROW0]    = CFG_DATA_W'(rand_row(plausible));
		v[REG_ROT_ROW1]    = CFG_DATA_W'(rand_row(plausible));
		v[REG_ROT_ROW2]    = CFG_DATA_W'(rand_row(plausible));
		v[REG_TRANSLATION] = rand60();
		case (kind)
			0: begin
				// Every register at an extreme, with junk above the width of most.
				v[REG_DEPTH_SCALE] = '1;
				v[REG_INV_FOCAL]   = '1;
				v[REG_PRINCIPAL]   = '1;
				v[REG_ROT_ROW0]    = 60'hFFF_7FFF_7FFF_7FFF;
				v[REG_ROT_ROW1]    = 60'hABC_8000_8000_8000;
				v[REG_ROT_ROW2]    = 60'h000_7FFF_8000_7FFF;
				v[REG_TRANSLATION] = 60'h7FFFF_80000_7FFFF;
			end
			1: begin
				// All zero except the most negative offsets.
				v[REG_DEPTH_SCALE] = '0;
				v[REG_INV_FOCAL]   = '0;
				v[REG_PRINCIPAL]   = '0;
				v[REG_ROT_ROW0]    = '0;
				v[REG_ROT_ROW1]    = '0;
				v[REG_ROT_ROW2]    = '0;
				v[REG_TRANSLATION] = 60'h80000_80000_80000;
			end
			2: begin
				// Zero reciprocal focal length with real depths.
				v[REG_INV_FOCAL] = '0;
			end
			default: ;
		endcase
		cfg_write(REG_DEPTH_SCALE, v[REG_DEPTH_SCALE]);
		cfg_write(REG_INV_FOCAL, v[REG_INV_FOCAL]);
		cfg_write(REG_PRINCIPAL, v[REG_PRINCIPAL]);
		cfg_write(REG_ROT_ROW0, v[REG_ROT_ROW0]);
		cfg_write(REG_ROT_ROW1, v[REG_ROT_ROW1]);
		cfg_write(REG_ROT_ROW2, v[REG_ROT_ROW2]);
		cfg_write(REG_TRANSLATION, v[REG_TRANSLATION]);
		cfg_write(REG_NONE, rand60());
	endtask

	initial begin
		pixel_t directed [$];
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset setting: field extremes, masked
		// pixels, zero depth and pixels around the principal point.
		directed = {directed, make_pixel(0, 0, 1000, 1, 8'h00, 8'hFF, 8'h00)};
		directed = {directed, make_pixel(2047, 2047, 65535, 255, 8'hFF, 8'h00, 8'hFF)};
		directed = {directed, make_pixel(100, 200, 1234, 0, 8'h12, 8'h34, 8'h56)};
		directed = {directed, make_pixel(500, 600, 0, 128, 8'hAA, 8'h55, 8'hAA)};
		directed = {directed, make_pixel(240, 320, 3000, 7, 8'h55, 8'hAA, 8'h55)};
		directed = {directed, make_pixel(239, 319, 3000, 64, 8'h01, 8'h80, 8'hFE)};
		directed = {directed, make_pixel(2047, 2047, 65535, 0, 8'hFF, 8'hFF, 8'hFF)};
		directed = {directed, make_pixel(2047, 0, 65535, 2, 8'h7F, 8'h7F, 8'h7F)};
		directed = {directed, make_pixel(0, 2047, 65535, 254, 8'h80, 8'h80, 8'h80)};
		directed = {directed, make_pixel(1365, 682, 43690, 170, 8'hC3, 8'h3C, 8'h99)};
		directed = {directed, make_pixel(682, 1365, 21845, 85, 8'h3C, 8'hC3, 8'h66)};
		directed = {directed, make_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00)};
		foreach (directed[i])
			send_pixel(directed[i]);
		stop_pixels();
		drain();

		// Random words under a series of register settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			apply_setting(ph);
			calm <= (ph == 4);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// Hold the sender back mid-phase until the pipeline is empty.
				if (ph == 6 && n == PHASE_LEN / 2) begin
					stop_pixels();
					drain();
				end
				send_pixel(rand_pixel());
			end
			stop_pixels();
			drain();
		end

		if (sb.errors == 0)
			$display("PASS masked_depth_to_point_transform");
		else
			$display("FAIL masked_depth_to_point_transform");
		$finish;
	end

endmodule
